### rtl/core/cartesian_to_polar_unwrap_core_macros.svh
// Assertion helpers shared by the core
`ifndef CARTESIAN_TO_POLAR_UNWRAP_CORE_MACROS_SVH
`define CARTESIAN_TO_POLAR_UNWRAP_CORE_MACROS_SVH

// Same-cycle implication, masked during reset
`define C2P_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset
`define C2P_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/c2p_pkg.sv
`default_nettype none

package c2p_pkg;

   // Fixed-point layout of the CORDIC engine
   localparam int DEG_FRAC   = 36;   // fraction bits of the angle accumulator
   localparam int TAB_BITS   = 42;   // width of one step angle
   localparam int ACC_BITS   = 46;   // signed angle accumulator
   localparam int CHUNK_BITS = 31;   // partial product operand width
   localparam int XY_BITS    = 2 * CHUNK_BITS;  // signed vector components
   localparam int PROD_BITS  = 4 * CHUNK_BITS;  // radius product
   localparam int GUARD_TOP  = 59;   // coordinates are scaled up to this bit

   // 180/pi as a ratio of integers
   localparam logic [63:0] DEG_NUM = 64'd65684340;
   localparam logic [63:0] DEG_DEN = 64'd1146408;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic prepare;
      logic iterate;
      logic finish_angle;
      logic multiply;
      logic load_out;
   } c2p_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic step_last;
      logic mul_last;
   } c2p_status_type;

   // Restoring division, used for elaboration-time tables only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      int          b;
      rem = '0;
      quo = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(2^-idx) in degrees with DEG_FRAC fraction bits
   function automatic logic [63:0] step_angle_fn(input int idx);
      logic [63:0] v;
      logic [63:0] term;
      logic [63:0] rad;
      logic [63:0] deg;
      int          k;
      int          e;
      v = '0;
      for (k = 0; k < 32; k++) begin
         e = idx * (2 * k + 1);
         if (e <= 62) begin
            term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
            if (k[0]) v = v - term;
            else v = v + term;
         end
      end
      rad = (v + (64'd1 << 25)) >> 26;
      deg = udiv64(rad * DEG_NUM + (DEG_DEN >> 1), DEG_DEN);
      if (idx == 0) deg = 64'd45 << DEG_FRAC;
      return deg;
   endfunction

   // Inverse CORDIC gain with 62 fraction bits
   function automatic logic [63:0] inv_gain_fn(input int steps);
      logic [63:0]  p;
      logic [127:0] n;
      logic [63:0]  r;
      logic [63:0]  t;
      logic [127:0] sq;
      int           i;
      int           b;
      p = 64'd1 << 62;
      for (i = 0; i < 64; i++) begin
         if (i < steps && 2 * i < 62) p = p - udiv64(p, (64'd1 << (2 * i)) + 64'd1);
      end
      n = 128'(p) << 62;
      r = '0;
      for (b = 63; b >= 0; b--) begin
         t  = r | (64'd1 << b);
         sq = 128'(t) * 128'(t);
         if (sq <= n) r = t;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/c2p_ctrl.sv
`default_nettype none

module c2p_ctrl
   import c2p_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output c2p_cmd_type         cmd,
   input  wire c2p_status_type status
);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StPrep  = 3'd1;
   localparam logic [2:0] StIter  = 3'd2;
   localparam logic [2:0] StAngle = 3'd3;
   localparam logic [2:0] StMul   = 3'd4;
   localparam logic [2:0] StDone  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   // Sequence one request through the datapath
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = StPrep;
            end
         end
         StPrep: begin
            cmd.prepare = 1'b1;
            state_in    = StIter;
         end
         StIter: begin
            cmd.iterate = 1'b1;
            if (status.step_last) state_in = StAngle;
         end
         StAngle: begin
            cmd.finish_angle = 1'b1;
            state_in         = StMul;
         end
         StMul: begin
            cmd.multiply = 1'b1;
            if (status.mul_last) state_in = StDone;
         end
         StDone: begin
            // hold until the output register is free or being drained
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // Output valid: set on load, drop when taken
   assign rsp_valid_in = cmd.load_out | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == StIdle);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/core/c2p_datapath.sv
`default_nettype none

module c2p_datapath
   import c2p_pkg::*;
#(
   parameter int COORD_BITS      = 32,
   parameter int ANGLE_FRAC_BITS = 16,
   parameter int CORDIC_STEPS    = 24,
   parameter int TURN_BITS       = 16
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire c2p_cmd_type                                   cmd,
   output c2p_status_type                                     status,
   input  wire logic signed [COORD_BITS-1:0]                  req_pos_x,
   input  wire logic signed [COORD_BITS-1:0]                  req_pos_y,
   input  wire logic signed [COORD_BITS-1:0]                  req_pos_z,
   output logic [COORD_BITS-1:0]                              rsp_radius,
   output logic signed [COORD_BITS-1:0]                       rsp_height,
   output logic signed [TURN_BITS+9+ANGLE_FRAC_BITS-1:0]      rsp_joint_angle,
   output logic signed [9+ANGLE_FRAC_BITS-1:0]                rsp_wrapped_angle,
   output logic signed [TURN_BITS-1:0]                        rsp_turn_count_out
);

   localparam int WrapBits   = 9 + ANGLE_FRAC_BITS;
   localparam int JointBits  = TURN_BITS + WrapBits;
   localparam int Guard      = GUARD_TOP - COORD_BITS;
   localparam int StepBits   = $clog2(CORDIC_STEPS);
   localparam int RoundShift = DEG_FRAC - ANGLE_FRAC_BITS;
   localparam int HiBits     = PROD_BITS - 64;
   localparam int RadSumBits = HiBits + 1;

   localparam logic [2:0] QuadNone = 3'd0;
   localparam logic [2:0] Quad1    = 3'd1;
   localparam logic [2:0] Quad2    = 3'd2;
   localparam logic [2:0] Quad3    = 3'd3;
   localparam logic [2:0] Quad4    = 3'd4;

   localparam logic [2:0] PhLl    = 3'd0;
   localparam logic [2:0] PhLh    = 3'd1;
   localparam logic [2:0] PhHl    = 3'd2;
   localparam logic [2:0] PhHh    = 3'd3;
   localparam logic [2:0] PhDrain = 3'd4;

   localparam logic signed [TURN_BITS-1:0] TurnMax =
      TURN_BITS'((64'd1 << (TURN_BITS - 1)) - 64'd1);
   localparam logic signed [TURN_BITS-1:0] TurnMin = -TurnMax;

   localparam logic signed [ACC_BITS-1:0] Acc180     = ACC_BITS'(64'd180 << DEG_FRAC);
   localparam logic signed [ACC_BITS-1:0] AccNeg180  = -Acc180;
   localparam logic signed [ACC_BITS-1:0] RoundBias  = ACC_BITS'(64'd1 << (RoundShift - 1));
   localparam logic signed [ACC_BITS-1:0] WrapLim    = ACC_BITS'(64'd180 << ANGLE_FRAC_BITS);
   localparam logic signed [ACC_BITS-1:0] WrapLimNeg = -WrapLim;

   localparam logic [63:0]           InvGain = inv_gain_fn(CORDIC_STEPS);
   localparam logic [CHUNK_BITS-1:0] GainLo  = InvGain[CHUNK_BITS-1:0];
   localparam logic [CHUNK_BITS-1:0] GainHi  = InvGain[2*CHUNK_BITS-1:CHUNK_BITS];
   localparam logic [RadSumBits-1:0] RadBias = RadSumBits'(64'd1 << (Guard - 3));

   // Step angle table, built at elaboration
   logic [TAB_BITS-1:0] angle_tab [CORDIC_STEPS];
   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_tab
      localparam logic [63:0] StepAngle = step_angle_fn(g);
      assign angle_tab[g] = StepAngle[TAB_BITS-1:0];
   end

   logic signed [COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic signed [COORD_BITS-1:0] pos_y_ff, pos_y_in;
   logic signed [COORD_BITS-1:0] pos_z_ff, pos_z_in;
   logic [2:0]                   last_quadrant_ff, last_quadrant_in;
   logic signed [TURN_BITS-1:0]  turn_count_ff, turn_count_in;
   logic signed [XY_BITS-1:0]    x_ff, x_in;
   logic signed [XY_BITS-1:0]    y_ff, y_in;
   logic signed [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [StepBits-1:0]          step_ff, step_in;
   logic                         zero_ff, zero_in;
   logic signed [JointBits-1:0]  offset_ff, offset_in;
   logic signed [WrapBits-1:0]   wrapped_ff, wrapped_in;
   logic [XY_BITS-1:0]           mag_ff, mag_in;
   logic [2:0]                   phase_ff, phase_in;
   logic [2*CHUNK_BITS-1:0]      pp_ff, pp_in;
   logic [PROD_BITS-1:0]         prod_ff, prod_in;

   logic [COORD_BITS-1:0]        rsp_radius_ff, rsp_radius_in;
   logic signed [COORD_BITS-1:0] rsp_height_ff, rsp_height_in;
   logic signed [JointBits-1:0]  rsp_joint_ff, rsp_joint_in;
   logic signed [WrapBits-1:0]   rsp_wrapped_ff, rsp_wrapped_in;
   logic signed [TURN_BITS-1:0]  rsp_turn_ff, rsp_turn_in;

   logic [2:0]                   req_quadrant;
   logic signed [XY_BITS-1:0]    x_wide, y_wide, x_sel, y_sel;
   logic signed [JointBits-1:0]  turn_wide;
   logic signed [XY_BITS-1:0]    dx, dy;
   logic signed [ACC_BITS-1:0]   step_angle;
   logic signed [ACC_BITS-1:0]   acc_round;
   logic signed [ACC_BITS-1:0]   acc_clamp;
   logic [CHUNK_BITS-1:0]        mul_a, mul_b;
   logic [HiBits-1:0]            prod_hi;
   logic [RadSumBits-1:0]        rad_sum, rad_shift;

   // Classify the incoming request by sign
   always_comb begin
      case ({req_pos_x[COORD_BITS-1], req_pos_y[COORD_BITS-1]})
         2'b00:   req_quadrant = Quad1;
         2'b10:   req_quadrant = Quad2;
         2'b11:   req_quadrant = Quad3;
         default: req_quadrant = Quad4;
      endcase
   end

   // Fold the left half plane onto the right one
   assign x_wide = {{(XY_BITS-COORD_BITS){pos_x_ff[COORD_BITS-1]}}, pos_x_ff};
   assign y_wide = {{(XY_BITS-COORD_BITS){pos_y_ff[COORD_BITS-1]}}, pos_y_ff};
   assign x_sel  = pos_x_ff[COORD_BITS-1] ? -x_wide : x_wide;
   assign y_sel  = pos_x_ff[COORD_BITS-1] ? -y_wide : y_wide;
   assign turn_wide = {{(JointBits-TURN_BITS){turn_count_ff[TURN_BITS-1]}}, turn_count_ff};

   // One CORDIC micro-rotation
   assign dx = y_ff >>> step_ff;
   assign dy = x_ff >>> step_ff;
   assign step_angle = $signed({{(ACC_BITS-TAB_BITS){1'b0}}, angle_tab[step_ff]});

   // Round the accumulator to the output grid and clamp to half a turn
   always_comb begin
      acc_round = (acc_ff + RoundBias) >>> RoundShift;
      acc_clamp = acc_round;
      if (acc_round > WrapLim) acc_clamp = WrapLim;
      if (acc_round < WrapLimNeg) acc_clamp = WrapLimNeg;
   end

   // Partial product operand select
   always_comb begin
      case (phase_ff)
         PhLl: begin
            mul_a = mag_ff[CHUNK_BITS-1:0];
            mul_b = GainLo;
         end
         PhLh: begin
            mul_a = mag_ff[CHUNK_BITS-1:0];
            mul_b = GainHi;
         end
         PhHl: begin
            mul_a = mag_ff[2*CHUNK_BITS-1:CHUNK_BITS];
            mul_b = GainLo;
         end
         PhHh: begin
            mul_a = mag_ff[2*CHUNK_BITS-1:CHUNK_BITS];
            mul_b = GainHi;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Round the scaled radius (it is saturated when the output register is loaded)
   assign prod_hi   = prod_ff[PROD_BITS-1:64];
   assign rad_sum   = {1'b0, prod_hi} + RadBias;
   assign rad_shift = rad_sum >> (Guard - 2);

   // Next-state logic of the datapath registers
   always_comb begin
      pos_x_in         = pos_x_ff;
      pos_y_in         = pos_y_ff;
      pos_z_in         = pos_z_ff;
      last_quadrant_in = last_quadrant_ff;
      turn_count_in    = turn_count_ff;
      x_in             = x_ff;
      y_in             = y_ff;
      acc_in           = acc_ff;
      step_in          = step_ff;
      zero_in          = zero_ff;
      offset_in        = offset_ff;
      wrapped_in       = wrapped_ff;
      mag_in           = mag_ff;
      phase_in         = phase_ff;
      pp_in            = pp_ff;
      prod_in          = prod_ff;
      rsp_radius_in    = rsp_radius_ff;
      rsp_height_in    = rsp_height_ff;
      rsp_joint_in     = rsp_joint_ff;
      rsp_wrapped_in   = rsp_wrapped_ff;
      rsp_turn_in      = rsp_turn_ff;

      // capture the request and step the turn count up or down
      if (cmd.capture) begin
         pos_x_in         = req_pos_x;
         pos_y_in         = req_pos_y;
         pos_z_in         = req_pos_z;
         last_quadrant_in = req_quadrant;
         if (last_quadrant_ff == Quad2 && req_quadrant == Quad3 && turn_count_ff < TurnMax)
            turn_count_in = turn_count_ff + TURN_BITS'(1);
         if (last_quadrant_ff == Quad3 && req_quadrant == Quad2 && turn_count_ff > TurnMin)
            turn_count_in = turn_count_ff - TURN_BITS'(1);
      end

      // load the vector, seed the accumulator, form 360 * turns
      if (cmd.prepare) begin
         x_in    = x_sel <<< Guard;
         y_in    = y_sel <<< Guard;
         acc_in  = '0;
         if (pos_x_ff[COORD_BITS-1]) acc_in = pos_y_ff[COORD_BITS-1] ? AccNeg180 : Acc180;
         step_in = '0;
         zero_in = (pos_x_ff == '0) && (pos_y_ff == '0);
         offset_in = (turn_wide <<< (8 + ANGLE_FRAC_BITS)) + (turn_wide <<< (6 + ANGLE_FRAC_BITS))
                   + (turn_wide <<< (5 + ANGLE_FRAC_BITS)) + (turn_wide <<< (3 + ANGLE_FRAC_BITS));
      end

      // rotate toward the x axis
      if (cmd.iterate) begin
         if (!y_ff[XY_BITS-1]) begin
            x_in   = x_ff + dx;
            y_in   = y_ff - dy;
            acc_in = acc_ff + step_angle;
         end else begin
            x_in   = x_ff - dx;
            y_in   = y_ff + dy;
            acc_in = acc_ff - step_angle;
         end
         step_in = step_ff + StepBits'(1);
      end

      // settle the angle, start the gain correction
      if (cmd.finish_angle) begin
         wrapped_in = zero_ff ? '0 : WrapBits'(acc_clamp);
         mag_in     = x_ff[XY_BITS-1] ? '0 : x_ff;
         phase_in   = PhLl;
         prod_in    = '0;
      end

      // multiply one chunk pair, accumulate the previous one
      if (cmd.multiply) begin
         pp_in    = (2 * CHUNK_BITS)'(mul_a) * (2 * CHUNK_BITS)'(mul_b);
         phase_in = phase_ff + 3'd1;
         case (phase_ff)
            PhLh:    prod_in = prod_ff + PROD_BITS'(pp_ff);
            PhHl:    prod_in = prod_ff + (PROD_BITS'(pp_ff) << CHUNK_BITS);
            PhHh:    prod_in = prod_ff + (PROD_BITS'(pp_ff) << CHUNK_BITS);
            PhDrain: prod_in = prod_ff + (PROD_BITS'(pp_ff) << (2 * CHUNK_BITS));
            default: prod_in = prod_ff;
         endcase
      end

      // fill the output register
      if (cmd.load_out) begin
         rsp_radius_in  = ((rad_shift >> COORD_BITS) != '0) ? '1 : rad_shift[COORD_BITS-1:0];
         rsp_height_in  = pos_z_ff;
         rsp_joint_in   = offset_ff
                        + {{(JointBits-WrapBits){wrapped_ff[WrapBits-1]}}, wrapped_ff};
         rsp_wrapped_in = wrapped_ff;
         rsp_turn_in    = turn_count_ff;
      end
   end

   // Turn tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_quadrant_ff <= QuadNone;
         turn_count_ff    <= '0;
      end else begin
         last_quadrant_ff <= last_quadrant_in;
         turn_count_ff    <= turn_count_in;
      end
   end

   // Working and output registers
   always_ff @(posedge clock) begin
      pos_x_ff       <= pos_x_in;
      pos_y_ff       <= pos_y_in;
      pos_z_ff       <= pos_z_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      acc_ff         <= acc_in;
      step_ff        <= step_in;
      zero_ff        <= zero_in;
      offset_ff      <= offset_in;
      wrapped_ff     <= wrapped_in;
      mag_ff         <= mag_in;
      phase_ff       <= phase_in;
      pp_ff          <= pp_in;
      prod_ff        <= prod_in;
      rsp_radius_ff  <= rsp_radius_in;
      rsp_height_ff  <= rsp_height_in;
      rsp_joint_ff   <= rsp_joint_in;
      rsp_wrapped_ff <= rsp_wrapped_in;
      rsp_turn_ff    <= rsp_turn_in;
   end

   assign status.step_last = (step_ff == StepBits'(CORDIC_STEPS - 1));
   assign status.mul_last  = (phase_ff == PhDrain);

   assign rsp_radius         = rsp_radius_ff;
   assign rsp_height         = rsp_height_ff;
   assign rsp_joint_angle    = rsp_joint_ff;
   assign rsp_wrapped_angle  = rsp_wrapped_ff;
   assign rsp_turn_count_out = rsp_turn_ff;

endmodule

`default_nettype wire

### rtl/core/cartesian_to_polar_unwrap_core.sv
// One request is handled at a time: the single shift-add CORDIC unit does one micro-rotation
// per cycle, followed by a four-pass radius multiply, and the next request is taken only
// once the result has been loaded into the output register.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active high) idles the controller, drops rsp_valid and clears the
// turn count and the last seen quadrant.
`default_nettype none

`include "cartesian_to_polar_unwrap_core_macros.svh"

module cartesian_to_polar_unwrap_core
   import c2p_pkg::*;
#(
   parameter int COORD_BITS      = 32,
   parameter int ANGLE_FRAC_BITS = 16,
   parameter int CORDIC_STEPS    = 24,
   parameter int TURN_BITS       = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_ready,
   input  wire logic signed [COORD_BITS-1:0]             req_pos_x,
   input  wire logic signed [COORD_BITS-1:0]             req_pos_y,
   input  wire logic signed [COORD_BITS-1:0]             req_pos_z,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_ready,
   output logic [COORD_BITS-1:0]                         rsp_radius,
   output logic signed [COORD_BITS-1:0]                  rsp_height,
   output logic signed [TURN_BITS+9+ANGLE_FRAC_BITS-1:0] rsp_joint_angle,
   output logic signed [9+ANGLE_FRAC_BITS-1:0]           rsp_wrapped_angle,
   output logic signed [TURN_BITS-1:0]                   rsp_turn_count_out
);

   localparam int WrapBits = 9 + ANGLE_FRAC_BITS;
   localparam logic signed [WrapBits-1:0]  WrapLim    = WrapBits'(64'd180 << ANGLE_FRAC_BITS);
   localparam logic signed [WrapBits-1:0]  WrapLimNeg = -WrapLim;
   localparam logic signed [TURN_BITS-1:0] TurnMin    = TURN_BITS'(64'd1 << (TURN_BITS - 1));

   c2p_cmd_type    cmd;
   c2p_status_type status;

   c2p_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   c2p_datapath #(
      .COORD_BITS      (COORD_BITS),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .CORDIC_STEPS    (CORDIC_STEPS),
      .TURN_BITS       (TURN_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_pos_z          (req_pos_z),
      .rsp_radius         (rsp_radius),
      .rsp_height         (rsp_height),
      .rsp_joint_angle    (rsp_joint_angle),
      .rsp_wrapped_angle  (rsp_wrapped_angle),
      .rsp_turn_count_out (rsp_turn_count_out)
   );

   // Only one request in flight
   `C2P_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")
   // Results appear only through an output load
   `C2P_ASSERT_NOW(a_valid_from_load, clock, reset, $rose(rsp_valid), $past(cmd.load_out), "rsp_valid without load")
   // Turn count saturates symmetrically
   `C2P_ASSERT_NOW(a_turn_sat, clock, reset, rsp_valid, rsp_turn_count_out != TurnMin, "turn count past its limit")
   // Wrapped angle stays within half a turn
   `C2P_ASSERT_NOW(a_wrap_range, clock, reset, rsp_valid, (rsp_wrapped_angle <= WrapLim) && (rsp_wrapped_angle >= WrapLimNeg), "wrapped angle out of range")

endmodule

`default_nettype wire

### dv/cartesian_to_polar_unwrap_core_test.sv
`default_nettype none

module cartesian_to_polar_unwrap_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS      = 32;
   localparam int ANGLE_FRAC_BITS = 16;
   localparam int CORDIC_STEPS    = 24;
   localparam int TURN_BITS       = 16;
   localparam int WRAP_BITS       = 9 + ANGLE_FRAC_BITS;
   localparam int JOINT_BITS      = TURN_BITS + 9 + ANGLE_FRAC_BITS;

   // Fixed-point layout of the angle accumulator and the scaled vector
   localparam int ACC_FRAC    = 36;
   localparam int GUARD_BITS  = 59 - COORD_BITS;
   localparam int TURN_MAX    = (1 << (TURN_BITS - 1)) - 1;
   localparam logic [63:0] DEG_SCALE_NUM = 64'd65684340;
   localparam logic [63:0] DEG_SCALE_DEN = 64'd1146408;
   localparam logic signed [63:0] ACC_HALF_TURN = 64'sd180 <<< ACC_FRAC;
   localparam logic signed [63:0] ANGLE_ROUND   = 64'sd1 <<< (ACC_FRAC - ANGLE_FRAC_BITS - 1);
   localparam logic signed [63:0] WRAP_LIMIT    = 64'sd180 <<< ANGLE_FRAC_BITS;
   localparam logic signed [63:0] FULL_TURN     = 64'sd360 <<< ANGLE_FRAC_BITS;

   // Run shape
   localparam int RANDOM_COUNT  = 1950;
   localparam int BURST_COUNT   = 12;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 64;
   localparam int LIMIT_CYCLES  = 2_000_000;

   localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] CMIN = 32'sh8000_0000;

   // Corner positions: first item in the lower left, turns both ways, origin, axes, extremes
   localparam int CORNER_COUNT = 24;
   localparam logic signed [31:0] CORNER_X [CORNER_COUNT] = '{
      -5, -7, -7, CMIN, CMIN, 0, CMAX, CMIN, CMIN, CMAX, 0, 0,
      CMAX, -1, -1, 1, 0, -1, 1, -1, -1, CMIN, -3, 0};
   localparam logic signed [31:0] CORNER_Y [CORNER_COUNT] = '{
      -5, 3, -3, 0, -1, 0, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX,
      0, 0, -1, 0, 1, 1, -1, 0, -1, -1, 5, -1};
   localparam logic signed [31:0] CORNER_Z [4] = '{CMIN, CMAX, 0, -1};

   typedef enum logic [2:0] {
      QUAD_NONE,
      QUAD_UPPER_RIGHT,
      QUAD_UPPER_LEFT,
      QUAD_LOWER_LEFT,
      QUAD_LOWER_RIGHT
   } quadrant_type;

   typedef struct {
      logic [COORD_BITS-1:0] radius;
      logic [COORD_BITS-1:0] height;
      logic [JOINT_BITS-1:0] joint;
      logic [WRAP_BITS-1:0]  wrapped;
      logic [TURN_BITS-1:0]  turns;
   } polar_result_type;

   // Tracks the turn count, predicts each polar result and checks the core against it
   class polar_scoreboard;
      logic signed [63:0] rot_angle [CORDIC_STEPS];
      logic [63:0]        gain_recip;
      quadrant_type       prev_quadrant;
      int                 turns;
      polar_result_type   expected_q [$];
      int                 accepted;
      int                 checked;
      int                 mismatches;
      int                 crossings;
      int                 axis_points;
      int                 turn_low;
      int                 turn_high;

      function new();
         logic [63:0]  series, term, rad, p, trial;
         logic [127:0] target;
         int           i, k, e, b;
         // Build the micro-rotation angles in degrees from an arctan series
         rot_angle[0] = 64'sd45 <<< ACC_FRAC;
         for (i = 1; i < CORDIC_STEPS; i++) begin
            series = '0;
            k = 0;
            e = i;
            while (e <= 62) begin
               term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
               if (k % 2 == 1) series = series - term;
               else series = series + term;
               k++;
               e = i * (2 * k + 1);
            end
            rad = (series + (64'd1 << 25)) >> 26;
            rot_angle[i] = (rad * DEG_SCALE_NUM + DEG_SCALE_DEN / 64'd2) / DEG_SCALE_DEN;
         end
         // Gain correction: square root of the product of 1/(1 + 4^-i) over the steps
         p = 64'd1 << 62;
         for (i = 0; i < CORDIC_STEPS; i++) begin
            if (2 * i < 62) p = p - p / ((64'd1 << (2 * i)) + 64'd1);
         end
         target = {2'b00, p, 62'd0};
         gain_recip = '0;
         for (b = 63; b >= 0; b--) begin
            trial = gain_recip | (64'd1 << b);
            if ({64'd0, trial} * {64'd0, trial} <= target) gain_recip = trial;
         end
         prev_quadrant = QUAD_NONE;
         turns = 0;
         accepted = 0;
         checked = 0;
         mismatches = 0;
         crossings = 0;
         axis_points = 0;
         turn_low = 0;
         turn_high = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Update the turn count and queue the polar result of one accepted request
      function void note_request(logic signed [31:0] px, logic signed [31:0] py,
                                 logic signed [31:0] pz);
         logic signed [63:0] vx, vy, dx, dy, acc, wrapped, joint;
         logic [127:0]       prod;
         logic [63:0]        scaled;
         quadrant_type       quad;
         polar_result_type   res;
         int                 i;
         if (px >= 0) quad = (py >= 0) ? QUAD_UPPER_RIGHT : QUAD_LOWER_RIGHT;
         else quad = (py >= 0) ? QUAD_UPPER_LEFT : QUAD_LOWER_LEFT;
         if (prev_quadrant == QUAD_UPPER_LEFT && quad == QUAD_LOWER_LEFT) begin
            crossings++;
            if (turns < TURN_MAX) turns++;
         end
         if (prev_quadrant == QUAD_LOWER_LEFT && quad == QUAD_UPPER_LEFT) begin
            crossings++;
            if (turns > -TURN_MAX) turns--;
         end
         prev_quadrant = quad;
         if (turns < turn_low) turn_low = turns;
         if (turns > turn_high) turn_high = turns;
         if (px == 0 || py == 0) axis_points++;

         wrapped = '0;
         res.radius = '0;
         if (px != 0 || py != 0) begin
            vx = 64'(px);
            vy = 64'(py);
            acc = '0;
            // Fold the left half plane over and start from +/-180 degrees
            if (px < 0) begin
               vx = -vx;
               vy = -vy;
               acc = (py < 0) ? -ACC_HALF_TURN : ACC_HALF_TURN;
            end
            vx = vx <<< GUARD_BITS;
            vy = vy <<< GUARD_BITS;
            for (i = 0; i < CORDIC_STEPS; i++) begin
               dx = vy >>> i;
               dy = vx >>> i;
               if (vy >= 0) begin
                  vx = vx + dx;
                  vy = vy - dy;
                  acc = acc + rot_angle[i];
               end else begin
                  vx = vx - dx;
                  vy = vy + dy;
                  acc = acc - rot_angle[i];
               end
            end
            acc = acc + ANGLE_ROUND;
            wrapped = acc >>> (ACC_FRAC - ANGLE_FRAC_BITS);
            if (wrapped > WRAP_LIMIT) wrapped = WRAP_LIMIT;
            if (wrapped < -WRAP_LIMIT) wrapped = -WRAP_LIMIT;
            // Scale the vector length by the inverse gain, round and saturate
            if (vx < 0) vx = '0;
            prod = {64'd0, vx} * {64'd0, gain_recip};
            scaled = (prod[127:64] + (64'd1 << (GUARD_BITS - 3))) >> (GUARD_BITS - 2);
            if (scaled[63:COORD_BITS] != '0) res.radius = '1;
            else res.radius = scaled[COORD_BITS-1:0];
         end
         joint = wrapped + 64'(turns) * FULL_TURN;
         res.height = pz;
         res.joint = joint[JOINT_BITS-1:0];
         res.wrapped = wrapped[WRAP_BITS-1:0];
         res.turns = turns[TURN_BITS-1:0];
         expected_q.push_back(res);
         accepted++;
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            mismatches++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         end
      endfunction

      // Match one delivered result against the oldest outstanding prediction
      function void check_response(logic [COORD_BITS-1:0] radius,
                                   logic [COORD_BITS-1:0] height,
                                   logic [JOINT_BITS-1:0] joint,
                                   logic [WRAP_BITS-1:0]  wrapped,
                                   logic [TURN_BITS-1:0]  turn_out);
         polar_result_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            $error("result with nothing outstanding: radius 0x%0h height 0x%0h",
                   radius, height);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         compare_field("radius", 64'(want.radius), 64'(radius));
         compare_field("height", 64'(want.height), 64'(height));
         compare_field("joint_angle", 64'(want.joint), 64'(joint));
         compare_field("wrapped_angle", 64'(want.wrapped), 64'(wrapped));
         compare_field("turn_count_out", 64'(want.turns), 64'(turn_out));
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic signed [COORD_BITS-1:0]   req_pos_x = '0;
   logic signed [COORD_BITS-1:0]   req_pos_y = '0;
   logic signed [COORD_BITS-1:0]   req_pos_z = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [COORD_BITS-1:0]          rsp_radius;
   logic signed [COORD_BITS-1:0]   rsp_height;
   logic signed [JOINT_BITS-1:0]   rsp_joint_angle;
   logic signed [WRAP_BITS-1:0]    rsp_wrapped_angle;
   logic signed [TURN_BITS-1:0]    rsp_turn_count_out;

   polar_scoreboard board;
   bit              rsp_steady = 1'b0;
   bit              rsp_hold_request = 1'b0;
   quadrant_type    walk_quad = QUAD_UPPER_RIGHT;
   int              walk_dir = 1;
   int              cycle_count = 0;

   cartesian_to_polar_unwrap_core #(
      .COORD_BITS      (COORD_BITS),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .CORDIC_STEPS    (CORDIC_STEPS),
      .TURN_BITS       (TURN_BITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_pos_z          (req_pos_z),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_radius         (rsp_radius),
      .rsp_height         (rsp_height),
      .rsp_joint_angle    (rsp_joint_angle),
      .rsp_wrapped_angle  (rsp_wrapped_angle),
      .rsp_turn_count_out (rsp_turn_count_out)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 16);
      return $urandom_range(30, 90);
   endfunction

   function automatic logic [30:0] draw_magnitude();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 2) return 31'($urandom_range(0, 3));
      if (pick < 5) return 31'($urandom_range(0, 65535));
      if (pick < 9) return 31'($urandom);
      return 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
   endfunction

   // Negative side covers -1 down to the most negative value
   function automatic logic signed [31:0] make_coord(bit negative);
      logic [30:0] mag;
      mag = draw_magnitude();
      if (negative) return ~{1'b0, mag};
      if ($urandom_range(0, 15) == 0) return '0;
      return {1'b0, mag};
   endfunction

   function automatic quadrant_type step_quadrant(quadrant_type q, int dir);
      return quadrant_type'(((int'(q) - 1 + dir + 4) % 4) + 1);
   endfunction

   // Walk around the circle so turns pile up, with some raw noise mixed in
   task automatic draw_position(output logic signed [31:0] px, output logic signed [31:0] py);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
         px = $urandom;
         py = $urandom;
      end else begin
         if (roll < 75) walk_quad = step_quadrant(walk_quad, walk_dir);
         else if (roll < 88) walk_quad = step_quadrant(walk_quad, -walk_dir);
         px = make_coord(walk_quad == QUAD_UPPER_LEFT || walk_quad == QUAD_LOWER_LEFT);
         py = make_coord(walk_quad == QUAD_LOWER_LEFT || walk_quad == QUAD_LOWER_RIGHT);
      end
   endtask

   // Present one request and hold it until the core takes it
   task automatic offer_position(input logic signed [31:0] px, input logic signed [31:0] py,
                                 input logic signed [31:0] pz);
      req_valid <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      do @(posedge clock); while (!req_ready);
      board.note_request(px, py, pz);
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop valid and wait for every outstanding result
   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Result side: random stalls, steady stretches, and a long hold-off on request
   initial begin : rsp_side
      int idle_left;
      int busy_left;
      idle_left = 0;
      busy_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            idle_left = HOLD_CYCLES;
            rsp_hold_request = 1'b0;
         end else if (idle_left == 0 && busy_left == 0 && !rsp_steady) begin
            idle_left = draw_gap();
            busy_left = $urandom_range(1, 24);
         end
         if (idle_left > 0) begin
            rsp_ready <= 1'b0;
            idle_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (busy_left > 0) busy_left--;
         end
      end
   end

   // Check every delivered result
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_response(rsp_radius, rsp_height, rsp_joint_angle, rsp_wrapped_angle,
                              rsp_turn_count_out);
   end

   // Abort a hung run
   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      int                 n;
      int                 gap;
      bit                 steady;
      logic signed [31:0] px, py;
      board = new();
      steady = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed corners and quadrant moves
      for (n = 0; n < CORNER_COUNT; n++) begin
         offer_position(CORNER_X[n], CORNER_Y[n], CORNER_Z[n % 4]);
         if (n % 3 == 2) idle_sender($urandom_range(1, 5));
      end

      // Random walk around the axis
      for (n = 0; n < RANDOM_COUNT; n++) begin
         if (n % 50 == 0) begin
            steady = ($urandom_range(0, 4) == 0);
            rsp_steady = steady;
            if ($urandom_range(0, 2) == 0) walk_dir = -walk_dir;
         end
         if (n == RANDOM_COUNT / 3 || n == 2 * RANDOM_COUNT / 3) begin
            // Stall the output long enough that requests back up into the core
            rsp_hold_request = 1'b1;
            repeat (BURST_COUNT) begin
               draw_position(px, py);
               offer_position(px, py, $urandom);
            end
            drain_results();
         end
         draw_position(px, py);
         offer_position(px, py, $urandom);
         gap = steady ? 0 : draw_gap();
         if (gap > 0) idle_sender(gap);
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d of %0d positions; turn count swept %0d to %0d over %0d crossings.",
               board.checked, board.accepted, board.turn_low, board.turn_high,
               board.crossings);
      $display("%0d positions on an axis or at the origin; %0d field mismatches.",
               board.axis_points, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0 && board.checked == board.accepted)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire

### cartesian_to_polar_unwrap_core.f
+incdir+rtl/core
rtl/core/c2p_pkg.sv
rtl/core/c2p_ctrl.sv
rtl/core/c2p_datapath.sv
rtl/core/cartesian_to_polar_unwrap_core.sv
dv/cartesian_to_polar_unwrap_core_test.sv
